// ----- src/lrukv_pkg.sv -----
// Shared types and constants for the LRU key-value cache.
// No dependencies; imported by the cache top level and its checker.
`default_nettype none

package lrukv_pkg;

    localparam int ENTRIES_DEF   = 16;
    localparam int KEY_BITS_DEF  = 16;
    localparam int DATA_BITS_DEF = 32;

    // Capacity register.
    localparam int                  CAP_BITS  = 5;
    localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

    // Request kinds carried in s_tuser.
    typedef enum logic {
        MODE_LOOKUP = 1'b0,
        MODE_WRITE  = 1'b1
    } mode_t;

    // Bit positions of the result flags in m_tuser.
    localparam int TUSER_HIT   = 0;
    localparam int TUSER_EVICT = 1;
    localparam int M_TUSER_W   = 2;

endpackage

`default_nettype wire

// ----- src/lrukv_ram.sv -----
// Simple dual-port synchronous RAM: one write port, one registered read port.
// Standalone; used by lru_key_value_cache for key/rank and value storage.
`default_nettype none

module lrukv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // A read of the address being written returns the old contents.
    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- src/lru_key_value_cache.sv -----
// Top level of the fully associative key-value cache with LRU replacement.
// Depends on lrukv_pkg and lrukv_ram.
`default_nettype none

// Usage:
// One request word enters on the s_ channel: s_tuser is the request kind
// (lookup or write) and s_tdata holds the key and the value to store. Each
// request gives exactly one result word on the m_ channel: m_tuser holds the
// hit and evicted flags, m_tdata the value read and the evicted key.
// The cap_reg register is written through cfg_valid/cfg_data, by the user only
// while the block is idle (not enforced by the block); cfg_ready is always high.
// Operation: a request scans every stored key and rank in the key/rank RAM, one
// entry a cycle, and then decides in ST_DECIDE. A lookup miss then loads its
// result. Any other request makes a second read-modify-write pass over the
// same RAM to age the recency ranks before its result is loaded. One request
// is in work at a time; the next is accepted in the cycle after the previous
// result is loaded into the output register, even while it waits for m_tready.
// Reset clears all valid marks, the occupancy count and the output valid flag,
// and sets the capacity to 16; no clearing pass is needed. If the receiver
// stalls, the result holds and a finished request waits for the output
// register before the block goes idle again.

module lru_key_value_cache
    import lrukv_pkg::*;
#(
    parameter int ENTRIES    = ENTRIES_DEF,
    parameter int KEY_BITS   = KEY_BITS_DEF,
    parameter int DATA_BITS  = DATA_BITS_DEF,
    localparam int S_TDATA_W = ((KEY_BITS + DATA_BITS + 7) / 8) * 8,
    localparam int M_TDATA_W = ((DATA_BITS + KEY_BITS + 7) / 8) * 8
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // Request channel.
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,  // key, write_value, zero pad
    input  wire logic                  s_tuser,  // mode
    // Result channel.
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [M_TDATA_W-1:0]  m_tdata,  // read_value, evicted_key, zero pad
    output logic      [M_TUSER_W-1:0]  m_tuser,  // hit, evicted
    // Capacity register write channel.
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CAP_BITS-1:0]   cfg_data
);

    localparam int IW   = $clog2(ENTRIES);
    localparam int RB   = IW;
    localparam int OW   = $clog2(ENTRIES + 1);
    localparam int CNTW = IW + 1;
    localparam int KRW  = KEY_BITS + RB;
    localparam logic [CNTW-1:0] CNT_END = CNTW'(ENTRIES);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_UPDATE,
        ST_DONE
    } state_t;

    state_t                state_reg;
    mode_t                 req_mode_reg;
    logic [KEY_BITS-1:0]   req_key_reg;
    logic [DATA_BITS-1:0]  req_val_reg;

    logic [CNTW-1:0]       cnt_reg;
    logic                  pipe_vld_reg;
    logic [IW-1:0]         pipe_idx_reg;

    logic                  found_reg;
    logic [IW-1:0]         found_idx_reg;
    logic [RB-1:0]         found_rank_reg;
    logic                  lru_ok_reg;
    logic [IW-1:0]         lru_idx_reg;
    logic [RB-1:0]         lru_rank_reg;
    logic [KEY_BITS-1:0]   lru_key_reg;
    logic                  free_ok_reg;
    logic [IW-1:0]         free_idx_reg;

    logic                  upd_ins_reg;
    logic [IW-1:0]         tgt_idx_reg;
    logic [RB-1:0]         thr_rank_reg;

    logic [ENTRIES-1:0]    valid_reg;
    logic [ENTRIES-1:0]    valid_next;
    logic [OW-1:0]         occ_reg;
    logic [CAP_BITS-1:0]   cap_reg;

    logic                  res_hit_reg;
    logic                  res_evict_reg;
    logic [KEY_BITS-1:0]   res_evkey_reg;

    logic                  m_valid_reg;
    logic                  m_hit_reg;
    logic                  m_evict_reg;
    logic [DATA_BITS-1:0]  m_rval_reg;
    logic [KEY_BITS-1:0]   m_evkey_reg;

    // RAM ports.
    logic                  kr_we;
    logic [IW-1:0]         kr_raddr;
    logic [KRW-1:0]        kr_wdata;
    logic [KRW-1:0]        kr_rdata;
    logic [KEY_BITS-1:0]   kr_key;
    logic [RB-1:0]         kr_rank;
    logic                  d_we;
    logic [IW-1:0]         d_waddr;
    logic [DATA_BITS-1:0]  d_rdata;

    // Entry update and replacement decisions.
    logic                  is_tgt;
    logic                  bump;
    logic                  evict_need;
    logic                  do_evict;
    logic                  ins_ok;
    logic [IW-1:0]         slot_idx;
    logic                  pipe_entry_valid;

    assign kr_key           = kr_rdata[KRW-1:RB];
    assign kr_rank          = kr_rdata[RB-1:0];
    assign kr_raddr         = cnt_reg[IW-1:0];
    assign pipe_entry_valid = valid_reg[pipe_idx_reg];

    // Clamped capacity test: occupancy >= max(1, min(cap, ENTRIES)).
    assign evict_need = (occ_reg != '0) &&
                        ((32'(occ_reg) >= 32'(cap_reg)) || (occ_reg == OW'(ENTRIES)));
    assign do_evict   = !found_reg && (req_mode_reg == MODE_WRITE) && evict_need && lru_ok_reg;
    // After an eviction the lowest free slot is the lower of the first free
    // entry and the one just evicted.
    assign slot_idx   = do_evict ? ((free_ok_reg && (free_idx_reg < lru_idx_reg)) ?
                                    free_idx_reg : lru_idx_reg)
                                 : free_idx_reg;
    assign ins_ok     = !found_reg && (req_mode_reg == MODE_WRITE) && (do_evict || free_ok_reg);

    // Valid marks after an insert; the new slot wins when it is the evicted one.
    always_comb begin
        valid_next = valid_reg;
        if (do_evict) begin
            valid_next[lru_idx_reg] = 1'b0;
        end
        valid_next[slot_idx] = 1'b1;
    end

    assign is_tgt = (pipe_idx_reg == tgt_idx_reg);
    assign bump   = pipe_entry_valid && (upd_ins_reg || (kr_rank < thr_rank_reg));
    assign kr_we  = (state_reg == ST_UPDATE) && pipe_vld_reg && (is_tgt || bump);
    assign kr_wdata = is_tgt ? {req_key_reg, RB'(0)} : {kr_key, kr_rank + RB'(1)};

    assign d_we    = (state_reg == ST_DECIDE) && (req_mode_reg == MODE_WRITE) &&
                     (found_reg || ins_ok);
    assign d_waddr = found_reg ? found_idx_reg : slot_idx;

    // Key and recency rank of every entry.
    lrukv_ram #(
        .WIDTH (KRW),
        .DEPTH (ENTRIES)
    ) u_key_rank_ram (
        .aclk  (aclk),
        .we    (kr_we),
        .waddr (pipe_idx_reg),
        .wdata (kr_wdata),
        .raddr (kr_raddr),
        .rdata (kr_rdata)
    );

    // Stored values; the read port follows the matched entry.
    lrukv_ram #(
        .WIDTH (DATA_BITS),
        .DEPTH (ENTRIES)
    ) u_data_ram (
        .aclk  (aclk),
        .we    (d_we),
        .waddr (d_waddr),
        .wdata (req_val_reg),
        .raddr (found_idx_reg),
        .rdata (d_rdata)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = M_TDATA_W'({m_evkey_reg, m_rval_reg});

    always_comb begin
        m_tuser              = '0;
        m_tuser[TUSER_HIT]   = m_hit_reg;
        m_tuser[TUSER_EVICT] = m_evict_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            valid_reg    <= '0;
            occ_reg      <= '0;
            cap_reg      <= CAP_RESET;
            m_valid_reg  <= 1'b0;
            pipe_vld_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                cap_reg <= cfg_data;
            end
            if (m_valid_reg && m_tready && (state_reg != ST_DONE)) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        req_mode_reg <= mode_t'(s_tuser);
                        req_key_reg  <= s_tdata[KEY_BITS-1:0];
                        req_val_reg  <= s_tdata[KEY_BITS +: DATA_BITS];
                        cnt_reg      <= '0;
                        pipe_vld_reg <= 1'b0;
                        found_reg    <= 1'b0;
                        lru_ok_reg   <= 1'b0;
                        free_ok_reg  <= 1'b0;
                        state_reg    <= ST_SCAN;
                    end
                end

                ST_SCAN: begin
                    pipe_vld_reg <= (cnt_reg < CNT_END);
                    pipe_idx_reg <= cnt_reg[IW-1:0];
                    if (cnt_reg < CNT_END) begin
                        cnt_reg <= cnt_reg + CNTW'(1);
                    end
                    if (pipe_vld_reg) begin
                        if (pipe_entry_valid && (kr_key == req_key_reg) && !found_reg) begin
                            found_reg      <= 1'b1;
                            found_idx_reg  <= pipe_idx_reg;
                            found_rank_reg <= kr_rank;
                        end
                        if (pipe_entry_valid && (!lru_ok_reg || (kr_rank > lru_rank_reg))) begin
                            lru_ok_reg   <= 1'b1;
                            lru_idx_reg  <= pipe_idx_reg;
                            lru_rank_reg <= kr_rank;
                            lru_key_reg  <= kr_key;
                        end
                        if (!pipe_entry_valid && !free_ok_reg) begin
                            free_ok_reg  <= 1'b1;
                            free_idx_reg <= pipe_idx_reg;
                        end
                    end
                    if ((cnt_reg == CNT_END) && !pipe_vld_reg) begin
                        state_reg <= ST_DECIDE;
                    end
                end

                ST_DECIDE: begin
                    res_hit_reg   <= found_reg;
                    res_evict_reg <= do_evict;
                    res_evkey_reg <= do_evict ? lru_key_reg : '0;
                    cnt_reg       <= '0;
                    pipe_vld_reg  <= 1'b0;
                    if (found_reg) begin
                        // Promote: entries more recent than the hit age by one.
                        upd_ins_reg  <= 1'b0;
                        tgt_idx_reg  <= found_idx_reg;
                        thr_rank_reg <= found_rank_reg;
                        state_reg    <= ST_UPDATE;
                    end else if (ins_ok) begin
                        if (!do_evict) begin
                            occ_reg <= occ_reg + OW'(1);
                        end
                        valid_reg <= valid_next;
                        // Insert: every other valid entry ages by one.
                        upd_ins_reg <= 1'b1;
                        tgt_idx_reg <= slot_idx;
                        state_reg   <= ST_UPDATE;
                    end else begin
                        state_reg <= ST_DONE;
                    end
                end

                ST_UPDATE: begin
                    pipe_vld_reg <= (cnt_reg < CNT_END);
                    pipe_idx_reg <= cnt_reg[IW-1:0];
                    if (cnt_reg < CNT_END) begin
                        cnt_reg <= cnt_reg + CNTW'(1);
                    end
                    if ((cnt_reg == CNT_END) && !pipe_vld_reg) begin
                        state_reg <= ST_DONE;
                    end
                end

                ST_DONE: begin
                    if (!m_valid_reg || m_tready) begin
                        m_valid_reg <= 1'b1;
                        m_hit_reg   <= res_hit_reg;
                        m_evict_reg <= res_evict_reg;
                        m_evkey_reg <= res_evkey_reg;
                        m_rval_reg  <= (res_hit_reg && (req_mode_reg == MODE_LOOKUP)) ?
                                       d_rdata : '0;
                        state_reg   <= ST_IDLE;
                    end
                end

                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- src/lrukv_checker.sv -----
// Port-level checks on the result channel of lru_key_value_cache.
// Depends on lrukv_pkg; attached to the top level by the bind at the end.
`default_nettype none

module lrukv_checker
    import lrukv_pkg::*;
#(
    parameter int KEY_BITS   = KEY_BITS_DEF,
    parameter int DATA_BITS  = DATA_BITS_DEF,
    localparam int M_TDATA_W = ((DATA_BITS + KEY_BITS + 7) / 8) * 8
) (
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata,
    input wire logic [M_TUSER_W-1:0] m_tuser
);

    // A stalled result word holds.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // Only an insert evicts, so a hit never reports an eviction.
    a_hit_no_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[TUSER_HIT] && m_tuser[TUSER_EVICT]))
        else $error("hit and eviction reported together");

    // A miss returns a zero value.
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[TUSER_HIT] |-> m_tdata[DATA_BITS-1:0] == '0)
        else $error("nonzero value on a miss");

    // Without an eviction the evicted key is zero.
    a_evkey_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[TUSER_EVICT] |-> m_tdata[DATA_BITS +: KEY_BITS] == '0)
        else $error("evicted key set without an eviction");

endmodule

bind lru_key_value_cache lrukv_checker #(
    .KEY_BITS  (KEY_BITS),
    .DATA_BITS (DATA_BITS)
) u_lrukv_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
